FILE: sv/hsv_pkg.sv
// shared types, constants and helpers for the hsv to rgb converter
`default_nettype none
package hsv_pkg;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [7:0]  FULL_SCALE = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // channel permutation codes, one per sextant
  localparam logic [2:0] PERM_VTP = 3'd0;
  localparam logic [2:0] PERM_QVP = 3'd1;
  localparam logic [2:0] PERM_PVT = 3'd2;
  localparam logic [2:0] PERM_PQV = 3'd3;
  localparam logic [2:0] PERM_TPV = 3'd4;
  localparam logic [2:0] PERM_VPQ = 3'd5;

  typedef struct packed {
    logic [16:0] s;
    logic [16:0] v;
    logic [15:0] f;
    logic [2:0]  perm;
  } hsv_work_t;

  function automatic logic [7:0] to_byte(input logic [16:0] x);
    logic [24:0] scaled;
    scaled = 25'(x) * 25'(FULL_SCALE);
    if (scaled[24:16] > 9'(FULL_SCALE)) begin
      return FULL_SCALE;
    end
    return scaled[23:16];
  endfunction

endpackage
`default_nettype wire

FILE: sv/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter
// a word pushed is written into the queue, then passes pipeline registers s1, s2 and s3 to the result ports
// sustained rate one word per cycle while pop keeps up with the results; the pipeline has three multiply stages
// a four-word queue between front end and pipeline absorbs result stalls
// synchronous reset empties the queue and the pipeline
`default_nettype none
module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [16:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  hsv_work_t front_word;
  hsv_work_t head_word;
  logic      head_valid;
  logic      head_take;

  hsv_front u_front (
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .word       (front_word)
  );

  hsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_word   (front_word),
    .full      (full),
    .rd_en     (head_take),
    .rd_word   (head_word),
    .not_empty (head_valid)
  );

  hsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_word),
    .head_valid (head_valid),
    .head_take  (head_take),
    .pop        (pop),
    .empty      (empty),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

endmodule
`default_nettype wire

FILE: sv/hsv_front.sv
// front end: clamps saturation and brightness, splits hue into sextant and fraction, picks permutation
`default_nettype none
module hsv_front
  import hsv_pkg::*;
(
  input  logic [16:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  output hsv_work_t   word
);

  logic [19:0] h6;
  logic [3:0]  sext;

  assign h6   = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign sext = h6[19:16];

  always_comb begin
    word.s = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
    word.v = (brightness > ONE_Q16) ? ONE_Q16 : brightness;
    word.f = h6[15:0];
    unique case (sext)
      4'd0:    word.perm = PERM_VTP;
      4'd1:    word.perm = PERM_QVP;
      4'd2:    word.perm = PERM_PVT;
      4'd3:    word.perm = PERM_PQV;
      4'd4:    word.perm = PERM_TPV;
      default: word.perm = PERM_VPQ;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hsv_queue.sv
// short queue between front end and arithmetic pipeline
`default_nettype none
module hsv_queue
  import hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  hsv_work_t wr_word,
  output logic      full,
  input  logic      rd_en,
  output hsv_work_t rd_word,
  output logic      not_empty
);

  hsv_work_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wptr;
  logic [QUEUE_AW-1:0]     rptr;
  logic [QUEUE_AW:0]       count;
  logic                    do_wr;
  logic                    do_rd;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_word   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_word;
    end
  end

endmodule
`default_nettype wire

FILE: sv/hsv_back.sv
// back end: three-stage elastic pipeline forming p, q, t and the byte channels
`default_nettype none
module hsv_back
  import hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hsv_work_t head,
  input  logic      head_valid,
  output logic      head_take,
  input  logic      pop,
  output logic      empty,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic        s1_valid;
  logic [16:0] s1_v;
  logic [2:0]  s1_perm;
  logic [16:0] s1_p;
  logic [15:0] s1_sf;
  logic [16:0] s1_snf;

  logic        s2_valid;
  logic [16:0] s2_v;
  logic [2:0]  s2_perm;
  logic [16:0] s2_p;
  logic [16:0] s2_q;
  logic [16:0] s2_t;

  logic        s3_valid;
  logic [7:0]  s3_r;
  logic [7:0]  s3_g;
  logic [7:0]  s3_b;

  logic        s1_load;
  logic        s2_load;
  logic        s3_load;

  logic [16:0] one_minus_s;
  logic [16:0] one_minus_f;
  logic [33:0] p_prod;
  logic [32:0] sf_prod;
  logic [33:0] snf_prod;
  logic [33:0] q_prod;
  logic [33:0] t_prod;
  logic [16:0] sel_r;
  logic [16:0] sel_g;
  logic [16:0] sel_b;

  assign s3_load   = !s3_valid || pop;
  assign s2_load   = !s2_valid || s3_load;
  assign s1_load   = !s1_valid || s2_load;
  assign head_take = head_valid && s1_load;

  // stage one: v*(1-s), s*f, s*(1-f)
  assign one_minus_s = ONE_Q16 - head.s;
  assign one_minus_f = ONE_Q16 - {1'b0, head.f};
  assign p_prod      = 34'(head.v) * 34'(one_minus_s);
  assign sf_prod     = 33'(head.s) * 33'(head.f);
  assign snf_prod    = 34'(head.s) * 34'(one_minus_f);

  // stage two: q and t
  assign q_prod = 34'(s1_v) * 34'(ONE_Q16 - {1'b0, s1_sf});
  assign t_prod = 34'(s1_v) * 34'(ONE_Q16 - s1_snf);

  // stage three: permutation and scaling to bytes
  always_comb begin
    unique case (s2_perm)
      PERM_VTP: begin sel_r = s2_v; sel_g = s2_t; sel_b = s2_p; end
      PERM_QVP: begin sel_r = s2_q; sel_g = s2_v; sel_b = s2_p; end
      PERM_PVT: begin sel_r = s2_p; sel_g = s2_v; sel_b = s2_t; end
      PERM_PQV: begin sel_r = s2_p; sel_g = s2_q; sel_b = s2_v; end
      PERM_TPV: begin sel_r = s2_t; sel_g = s2_p; sel_b = s2_v; end
      default:  begin sel_r = s2_v; sel_g = s2_p; sel_b = s2_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= head_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (s3_load) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      s1_v    <= head.v;
      s1_perm <= head.perm;
      s1_p    <= p_prod[32:16];
      s1_sf   <= sf_prod[31:16];
      s1_snf  <= snf_prod[32:16];
    end
    if (s2_load && s1_valid) begin
      s2_v    <= s1_v;
      s2_perm <= s1_perm;
      s2_p    <= s1_p;
      s2_q    <= q_prod[32:16];
      s2_t    <= t_prod[32:16];
    end
    if (s3_load && s2_valid) begin
      s3_r <= to_byte(sel_r);
      s3_g <= to_byte(sel_g);
      s3_b <= to_byte(sel_b);
    end
  end

  assign empty = !s3_valid;
  assign red   = s3_r;
  assign green = s3_g;
  assign blue  = s3_b;

endmodule
`default_nettype wire

FILE: sv/hsv_checker.sv
// port-level checks for the hsv to rgb converter, bound to the top level
`default_nettype none
module hsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue
);

  // result word stays until popped
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped before pop");

  // stalled result word keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(red) && $stable(green) && $stable(blue)))
    else $error("stalled result word changed");

  // queue can only fill while the pipeline is backed up to the output
  a_full_backed: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full with no result waiting");

  // full only rises after a pushed word
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("queue went full with no word pushed");

  // reset empties both sides
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not empty after reset");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);
`default_nettype wire
